FILE: rtl/gti_pkg.sv
`default_nettype none
package gti_pkg;

  localparam int GRID_SIDE = 32;
  localparam int AXIS_W    = $clog2(GRID_SIDE);
  localparam int ADDR_W    = 3 * AXIS_W;
  localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 21;
  localparam int FRAC_W    = 16;
  localparam int WGT_W     = 16;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_INTERP = 1'b1;

  localparam logic MODE_TSC = 1'b0;
  localparam logic MODE_NGP = 1'b1;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_NGP   = 2'd1;
  localparam logic [1:0] KIND_TSC   = 2'd2;

  // one classified request, front to back
  typedef struct packed {
    logic [1:0]                  kind;
    logic [ADDR_W-1:0]           addr;
    logic [DATA_W-1:0]           data;
    logic [2:0][AXIS_W-1:0]      base;
    logic [2:0][2:0][WGT_W-1:0]  wgt;
  } job_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } ram_req_t;

endpackage
`default_nettype wire

FILE: rtl/gti_ram.sv
`default_nettype none
module gti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32768,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: rtl/gti_front.sv
`default_nettype none
module gti_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_req_type,
  input  wire logic [gti_pkg::ADDR_W-1:0]  in_cell_index,
  input  wire logic [gti_pkg::DATA_W-1:0]  in_cell_value,
  input  wire logic [gti_pkg::POS_W-1:0]   in_pos_x,
  input  wire logic [gti_pkg::POS_W-1:0]   in_pos_y,
  input  wire logic [gti_pkg::POS_W-1:0]   in_pos_z,
  input  wire logic                        mode,
  output logic                             q_push,
  output gti_pkg::job_t                    q_data,
  input  wire logic                        q_full
);
  import gti_pkg::*;

  logic                        f_valid_r;
  logic [1:0]                  f_kind_r;
  logic [ADDR_W-1:0]           f_addr_r;
  logic [DATA_W-1:0]           f_data_r;
  logic [2:0][POS_W-1:0]       f_pos_r;
  logic [1:0]                  f_ax_r;
  logic [2:0][AXIS_W-1:0]      f_base_r;
  logic [2:0][2:0][WGT_W-1:0]  f_wgt_r;

  logic              accept, ready;
  logic [POS_W-1:0]  p;
  logic [FRAC_W-1:0] fr;
  logic [16:0]       a, b, u;
  logic [33:0]       a_sq, b_sq, u_sq;
  logic [33:0]       a_t, b_t;
  logic [31:0]       m_t;
  logic [AXIS_W-1:0] base;
  logic [2:0][WGT_W-1:0] w;

  // one axis per cycle: wrapped lower cell and its three weights
  always_comb begin
    p  = f_pos_r[f_ax_r];
    fr = p[FRAC_W-1:0];
    if (!fr[FRAC_W-1]) begin
      a    = 17'h08000 - {1'b0, fr};
      b    = 17'h08000 + {1'b0, fr};
      u    = {1'b0, fr};
      base = p[FRAC_W +: AXIS_W] + AXIS_W'(GRID_SIDE - 1);
    end else begin
      a    = 17'h18000 - {1'b0, fr};
      b    = {1'b0, fr} - 17'h08000;
      u    = 17'h10000 - {1'b0, fr};
      base = p[FRAC_W +: AXIS_W];
    end
    a_sq = 34'(a) * 34'(a);
    b_sq = 34'(b) * 34'(b);
    u_sq = 34'(u) * 34'(u);
    a_t  = a_sq + 34'h10000;
    b_t  = b_sq + 34'h10000;
    m_t  = 32'hC000_0000 - u_sq[31:0] + 32'h8000;
    w[0] = a_t[32:17];
    w[1] = m_t[31:16];
    w[2] = b_t[32:17];
  end

  assign ready    = (f_kind_r != KIND_TSC) || (f_ax_r == 2'd3);
  assign q_push   = f_valid_r && ready && !q_full;
  assign in_stall = f_valid_r && !q_push;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
      f_ax_r    <= 2'd0;
    end else begin
      if (accept) begin
        f_valid_r <= 1'b1;
        f_ax_r    <= 2'd0;
      end else begin
        if (q_push) begin
          f_valid_r <= 1'b0;
        end
        if (f_valid_r && f_kind_r == KIND_TSC && f_ax_r != 2'd3) begin
          f_ax_r <= f_ax_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_data_r   <= in_cell_value;
      f_pos_r[0] <= in_pos_x;
      f_pos_r[1] <= in_pos_y;
      f_pos_r[2] <= in_pos_z;
      if (in_req_type == REQ_WRITE) begin
        f_kind_r <= KIND_WRITE;
        f_addr_r <= in_cell_index;
      end else begin
        f_kind_r <= (mode == MODE_NGP) ? KIND_NGP : KIND_TSC;
        f_addr_r <= {in_pos_x[FRAC_W +: AXIS_W], in_pos_y[FRAC_W +: AXIS_W],
                     in_pos_z[FRAC_W +: AXIS_W]};
      end
    end else if (f_valid_r && f_kind_r == KIND_TSC && f_ax_r != 2'd3) begin
      f_base_r[f_ax_r] <= base;
      f_wgt_r[f_ax_r]  <= w;
    end
  end

  always_comb begin
    q_data.kind = f_kind_r;
    q_data.addr = f_addr_r;
    q_data.data = f_data_r;
    q_data.base = f_base_r;
    q_data.wgt  = f_wgt_r;
  end

endmodule
`default_nettype wire

FILE: rtl/gti_queue.sv
`default_nettype none
module gti_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  gti_pkg::job_t      push_data,
  output logic               full,
  input  wire logic          pop,
  output gti_pkg::job_t      head,
  output logic               empty
);
  import gti_pkg::*;

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/gti_back.sv
`default_nettype none
module gti_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_empty,
  input  gti_pkg::job_t                   q_head,
  output logic                            q_pop,
  output gti_pkg::ram_req_t               ram_req,
  input  wire logic [gti_pkg::DATA_W-1:0] ram_rdata,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [gti_pkg::DATA_W-1:0]      out_interp_value
);
  import gti_pkg::*;

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_TSC   = 3'd1;
  localparam logic [2:0] B_NGP   = 3'd2;
  localparam logic [2:0] B_DRAIN = 3'd3;
  localparam logic [2:0] B_DONE  = 3'd4;

  logic [2:0]                  st_r, st_nxt;
  logic [2:0][AXIS_W-1:0]      base_r;
  logic [2:0][2:0][WGT_W-1:0]  wgt_r;
  logic [1:0]                  i_r, j_r, k_r;
  logic                        p1_v_r, p2_v_r, p3_v_r;
  logic [31:0]                 p1_wxy_r;
  logic [WGT_W-1:0]            p1_wz_r;
  logic [29:0]                 p2_wq_r;
  logic signed [DATA_W-1:0]    p2_val_r;
  logic signed [62:0]          p3_prod_r;
  logic signed [63:0]          acc_r;
  logic [DATA_W-1:0]           res_r;
  logic                        out_valid_r;
  logic [DATA_W-1:0]           out_value_r;

  logic              issue, last, out_free, pipe_empty, load_out;
  logic [47:0]       w_full, w_rnd;
  logic signed [64:0] acc_rnd;
  logic signed [34:0] r_q;
  logic [DATA_W-1:0] sat_val;

  assign issue      = (st_r == B_TSC);
  assign last       = (i_r == 2'd2) && (j_r == 2'd2) && (k_r == 2'd2);
  assign out_free   = !out_valid_r || !out_stall;
  assign pipe_empty = !p1_v_r && !p2_v_r && !p3_v_r;
  assign load_out   = (st_r == B_DONE) && out_free;

  assign w_full  = 48'(p1_wxy_r) * 48'(p1_wz_r);
  assign w_rnd   = w_full + 48'h20000;
  assign acc_rnd = 65'(acc_r) + 65'sh2000_0000;
  assign r_q     = acc_rnd[64:30];

  // saturate to signed 32 bits
  always_comb begin
    if (r_q[34:31] == 4'b0000 || r_q[34:31] == 4'b1111) begin
      sat_val = r_q[31:0];
    end else if (r_q[34]) begin
      sat_val = 32'h8000_0000;
    end else begin
      sat_val = 32'h7FFF_FFFF;
    end
  end

  always_comb begin
    q_pop         = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.addr  = q_head.addr;
    ram_req.wdata = q_head.data;
    st_nxt        = st_r;
    unique case (st_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_head.kind == KIND_WRITE) begin
            ram_req.we = 1'b1;
          end else if (q_head.kind == KIND_NGP) begin
            st_nxt = B_NGP;
          end else begin
            st_nxt = B_TSC;
          end
        end
      end
      B_TSC: begin
        ram_req.addr = {base_r[0] + AXIS_W'(i_r), base_r[1] + AXIS_W'(j_r),
                        base_r[2] + AXIS_W'(k_r)};
        if (last) begin
          st_nxt = B_DRAIN;
        end
      end
      B_NGP: st_nxt = B_DONE;
      B_DRAIN: begin
        if (pipe_empty) begin
          st_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (out_free) begin
          st_nxt = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      p3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      i_r         <= 2'd0;
      j_r         <= 2'd0;
      k_r         <= 2'd0;
    end else begin
      st_r   <= st_nxt;
      p1_v_r <= issue;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (st_r == B_IDLE) begin
        i_r <= 2'd0;
        j_r <= 2'd0;
        k_r <= 2'd0;
      end else if (issue) begin
        if (k_r == 2'd2) begin
          k_r <= 2'd0;
          if (j_r == 2'd2) begin
            j_r <= 2'd0;
            i_r <= i_r + 2'd1;
          end else begin
            j_r <= j_r + 2'd1;
          end
        end else begin
          k_r <= k_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == B_IDLE && q_pop) begin
      base_r <= q_head.base;
      wgt_r  <= q_head.wgt;
      acc_r  <= '0;
    end else if (p3_v_r) begin
      acc_r <= acc_r + 64'(p3_prod_r);
    end
    p1_wxy_r  <= 32'(wgt_r[0][i_r]) * 32'(wgt_r[1][j_r]);
    p1_wz_r   <= wgt_r[2][k_r];
    p2_wq_r   <= w_rnd[47:18];
    p2_val_r  <= ram_rdata;
    p3_prod_r <= 63'($signed({1'b0, p2_wq_r})) * 63'(p2_val_r);
    if (st_r == B_NGP) begin
      res_r <= ram_rdata;
    end else if (st_r == B_DRAIN && pipe_empty) begin
      res_r <= sat_val;
    end
    if (load_out) begin
      out_value_r <= res_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_interp_value = out_value_r;

endmodule
`default_nettype wire

FILE: rtl/grid_tsc_interpolator.sv
// channel  | direction | beat contents
// in_      | input     | req_type, cell_index, cell_value, pos_x, pos_y, pos_z
// out_     | output    | interp_value
// p*      | APB       | interp_mode at byte address 0
//
// A write beat occupies the back end only while it is popped; a nearest-grid-point
// query reads one cell; a TSC query makes 27 reads on the single grid RAM port,
// then drains multiply/accumulate and loads the result. Front axis setup overlaps.
// Reset clears control state and interp_mode; grid contents stay undefined.
// A two-entry queue decouples front and back; a stalled out_ beat holds the back.
`default_nettype none
module grid_tsc_interpolator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_req_type,
  input  wire logic [gti_pkg::ADDR_W-1:0]  in_cell_index,
  input  wire logic [gti_pkg::DATA_W-1:0]  in_cell_value,
  input  wire logic [gti_pkg::POS_W-1:0]   in_pos_x,
  input  wire logic [gti_pkg::POS_W-1:0]   in_pos_y,
  input  wire logic [gti_pkg::POS_W-1:0]   in_pos_z,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [gti_pkg::DATA_W-1:0]       out_interp_value,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import gti_pkg::*;

  logic     mode_r;
  logic     q_push, q_full, q_pop, q_empty;
  job_t     q_in, q_head;
  ram_req_t ram_req;
  logic [DATA_W-1:0] ram_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_TSC;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      mode_r <= pwdata[0];
    end
  end

  gti_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_req_type, .in_cell_index,
    .in_cell_value, .in_pos_x, .in_pos_y, .in_pos_z,
    .mode(mode_r), .q_push, .q_data(q_in), .q_full
  );

  gti_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .head(q_head), .empty(q_empty)
  );

  gti_ram #(.WIDTH(DATA_W), .DEPTH(GRID_CELLS)) u_grid (
    .clk, .we(ram_req.we), .addr(ram_req.addr), .wdata(ram_req.wdata),
    .rdata(ram_rdata)
  );

  gti_back u_back (
    .clk, .rst_n, .q_empty, .q_head, .q_pop, .ram_req, .ram_rdata,
    .out_valid, .out_stall, .out_interp_value
  );

  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty)) else $error("queue full and empty at once");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("pop from empty queue");

  a_write_pops: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> q_pop) else $error("grid write without a queued write beat");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("push into full queue");

endmodule
`default_nettype wire

FILE: verif/tb_grid_tsc_interpolator.sv
`default_nettype none
module tb_grid_tsc_interpolator;
  import gti_pkg::*;

  localparam int LIMIT = 3000000;

  typedef struct packed {
    logic              req;
    logic [ADDR_W-1:0] idx;
    logic [DATA_W-1:0] val;
    logic [POS_W-1:0]  px;
    logic [POS_W-1:0]  py;
    logic [POS_W-1:0]  pz;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  beat_t cur = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DATA_W-1:0] out_interp_value;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  grid_tsc_interpolator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(cur.req), .in_cell_index(cur.idx), .in_cell_value(cur.val),
    .in_pos_x(cur.px), .in_pos_y(cur.py), .in_pos_z(cur.pz),
    .out_valid(out_valid), .out_stall(out_stall), .out_interp_value(out_interp_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [DATA_W-1:0] grid_img [GRID_CELLS];
  logic mode_shadow = MODE_TSC;
  beat_t pending_beats[$];
  logic [DATA_W-1:0] expected_vals[$];
  logic calm = 1'b0;
  int mismatches = 0;
  int results_got = 0;
  int cycles = 0;

  function automatic void axis_setup(input logic [POS_W-1:0] pos, output int idx[3],
                                     output longint w[3]);
    longint f, a, b, u2;
    int c;
    f = longint'(pos[FRAC_W-1:0]);
    c = int'(pos[POS_W-1:FRAC_W]);
    if (f < 'h8000) begin
      a = 'h8000 - f;
      b = 'h8000 + f;
      u2 = f * f;
    end else begin
      c = c + 1;
      a = 'h18000 - f;
      b = f - 'h8000;
      u2 = ('h10000 - f) * ('h10000 - f);
    end
    w[0] = (a * a + 'h10000) >>> 17;
    w[1] = ((longint'(3) << 30) - u2 + 'h8000) >>> 16;
    w[2] = (b * b + 'h10000) >>> 17;
    for (int k = 0; k < 3; k++) idx[k] = (c + GRID_SIDE - 1 + k) % GRID_SIDE;
  endfunction

  function automatic logic [DATA_W-1:0] tsc_sum(beat_t bt);
    int ix[3], iy[3], iz[3];
    longint wx[3], wy[3], wz[3];
    longint acc, wq, r;
    logic [63:0] biased;
    axis_setup(bt.px, ix, wx);
    axis_setup(bt.py, iy, wy);
    axis_setup(bt.pz, iz, wz);
    acc = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        for (int k = 0; k < 3; k++) begin
          wq = (wx[i] * wy[j] * wz[k] + 'h20000) >>> 18;
          acc += wq * longint'($signed(grid_img[(ix[i] * GRID_SIDE + iy[j]) * GRID_SIDE
                                                + iz[k]]));
        end
    biased = 64'(acc) + (64'd1 << 29) + (64'd1 << 62);
    r = longint'(biased >> 30) - (longint'(1) << 32);
    if (r > 64'sh7FFFFFFF) r = 64'sh7FFFFFFF;
    if (r < -64'sh80000000) r = -64'sh80000000;
    return r[31:0];
  endfunction

  function automatic void grid_apply(beat_t bt);
    int x, y, z;
    if (bt.req == REQ_WRITE) begin
      grid_img[bt.idx] = bt.val;
    end else if (mode_shadow == MODE_NGP) begin
      x = int'(bt.px[POS_W-1:FRAC_W]) % GRID_SIDE;
      y = int'(bt.py[POS_W-1:FRAC_W]) % GRID_SIDE;
      z = int'(bt.pz[POS_W-1:FRAC_W]) % GRID_SIDE;
      expected_vals.push_back(grid_img[(x * GRID_SIDE + y) * GRID_SIDE + z]);
    end else begin
      expected_vals.push_back(tsc_sum(bt));
    end
  endfunction

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    logic take, nv;
    take = in_valid && !in_stall;
    if (rst_n) begin
      if (take) grid_apply(cur);
      if (!in_valid || take) begin
        nv = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (!calm && $urandom_range(0, 15) == 0) begin
          send_gap = $urandom_range(0, 12);
        end else if (pending_beats.size() > 0) begin
          cur <= pending_beats.pop_front();
          nv = 1'b1;
        end
        in_valid <= nv;
      end
    end
  end

  // monitor
  int stall_left = 0;
  logic long_hold_done = 1'b0;
  always @(posedge clk) begin
    logic [DATA_W-1:0] want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_got++;
        if (expected_vals.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: got %h", out_interp_value);
        end else begin
          want = expected_vals.pop_front();
          if (want !== out_interp_value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("interp_value mismatch: expected %h got %h", want, out_interp_value);
          end
        end
      end
      // one long receiver hold so the block backs up into in_stall
      if (!long_hold_done && results_got == 150) begin
        long_hold_done = 1'b1;
        stall_left = 500;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_write(int idx, logic [31:0] val);
    beat_t bt;
    bt = '0;
    bt.req = REQ_WRITE;
    bt.idx = ADDR_W'(idx);
    bt.val = val;
    bt.px = POS_W'($urandom);
    bt.py = POS_W'($urandom);
    bt.pz = POS_W'($urandom);
    pending_beats.push_back(bt);
  endtask

  task automatic push_query(logic [POS_W-1:0] x, logic [POS_W-1:0] y, logic [POS_W-1:0] z);
    beat_t bt;
    bt.req = REQ_INTERP;
    bt.idx = ADDR_W'($urandom);
    bt.val = $urandom;
    bt.px = x;
    bt.py = y;
    bt.pz = z;
    pending_beats.push_back(bt);
  endtask

  task automatic drain();
    while (pending_beats.size() > 0 || in_valid || expected_vals.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_mode(logic m);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= '0;
    pwdata <= {31'd0, m};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    mode_shadow = m;
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // integer part 31, 0 or 1: TSC cells stay within 30..3 on each axis
  function automatic logic [POS_W-1:0] rand_pos();
    logic [AXIS_W-1:0] ip;
    ip = AXIS_W'($urandom_range(0, 2) + GRID_SIDE - 1);
    return {ip, FRAC_W'($urandom)};
  endfunction

  task automatic directed_queries();
    push_query('0, '0, '0);
    push_query('1, '1, '1);
    push_query(21'h0A8000, 21'h0A8000, 21'h0A8000);   // exact half fraction
    push_query(21'h0A7FFF, 21'h0A0000, 21'h0A4000);
    push_query(21'h0AFFFF, 21'h0A3000, 21'h09C000);
    push_query(21'h1F8000, 21'h008000, 21'h1FFFFF);   // wraps past grid edge
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // queries only touch the block around the origin corner and cells 9..12
    for (int x = GRID_SIDE - 2; x < GRID_SIDE + 4; x++)
      for (int y = GRID_SIDE - 2; y < GRID_SIDE + 4; y++)
        for (int z = GRID_SIDE - 2; z < GRID_SIDE + 4; z++)
          push_write(((x % GRID_SIDE) * GRID_SIDE + y % GRID_SIDE) * GRID_SIDE
                     + z % GRID_SIDE, rand_sample());
    for (int x = 9; x <= 12; x++)
      for (int y = 9; y <= 12; y++)
        for (int z = 9; z <= 12; z++)
          push_write((x * GRID_SIDE + y) * GRID_SIDE + z, rand_sample());
    drain();
    push_write(0, 32'h80000000);
    push_write(GRID_CELLS - 1, 32'h7FFFFFFF);
    for (int x = 9; x <= 11; x++)
      for (int y = 9; y <= 11; y++)
        for (int z = 9; z <= 11; z++)
          push_write((x * GRID_SIDE + y) * GRID_SIDE + z, 32'h7FFFFFFF);
    directed_queries();
    drain();
    set_mode(MODE_NGP);
    directed_queries();
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      set_mode(ph[0] ? MODE_NGP : MODE_TSC);
      if (ph == 3) calm = 1'b1;
      for (int n = 0; n < 385; n++) begin
        if ($urandom_range(0, 1) == 0)
          push_write($urandom_range(0, GRID_CELLS - 1), rand_sample());
        else
          push_query(rand_pos(), rand_pos(), rand_pos());
      end
      drain();
    end
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/gti_pkg.sv
rtl/gti_ram.sv
rtl/gti_front.sv
rtl/gti_queue.sv
rtl/gti_back.sv
rtl/grid_tsc_interpolator.sv
verif/tb_grid_tsc_interpolator.sv
